// ----- rtl/core/pal_pkg.sv -----
// ----------------------------------------------------------------------------
// pal_pkg
// Shared codes and controller/datapath signal groups for the positional
// array list.
// ----------------------------------------------------------------------------
package pal_pkg;

  // Command codes carried on the command input.
  localparam logic [1:0] CMD_READ   = 2'd0;
  localparam logic [1:0] CMD_MODIFY = 2'd1;
  localparam logic [1:0] CMD_INSERT = 2'd2;
  localparam logic [1:0] CMD_DELETE = 2'd3;

  // Memory read address selects.
  localparam logic [2:0] RD_AT      = 3'd0;  // position - 1
  localparam logic [2:0] RD_LAST    = 3'd1;  // count - 1
  localparam logic [2:0] RD_PTR_DN  = 3'd2;  // ptr - 1
  localparam logic [2:0] RD_PTR_UP1 = 3'd3;  // ptr + 1
  localparam logic [2:0] RD_PTR_UP2 = 3'd4;  // ptr + 2

  // Memory write selects.
  localparam logic [1:0] WR_AT_VALUE = 2'd0;  // mem[position - 1] = value
  localparam logic [1:0] WR_PTR_UP   = 2'd1;  // mem[ptr + 1] = read data
  localparam logic [1:0] WR_PTR      = 2'd2;  // mem[ptr] = read data

  // Sweep pointer operations.
  localparam logic [2:0] PTR_HOLD      = 3'd0;
  localparam logic [2:0] PTR_LOAD_AT   = 3'd1;
  localparam logic [2:0] PTR_LOAD_LAST = 3'd2;
  localparam logic [2:0] PTR_DEC       = 3'd3;
  localparam logic [2:0] PTR_INC       = 3'd4;

  typedef struct packed {
    logic       latch;      // take in a new item
    logic       rd_en;
    logic [2:0] rd_sel;
    logic       wr_en;
    logic [1:0] wr_sel;
    logic [2:0] ptr_op;
    logic       cap_prior;  // keep the word just read as the old value
    logic       finish;     // commit count and load the result register
  } pal_cmd_t;

  typedef struct packed {
    logic [1:0] cmd;
    logic       bad;        // request refused
    logic       append;     // insert lands just past the last entry
    logic       ptr_at;     // ptr has reached position - 1
    logic       del_last;   // ptr + 1 == count
    logic       del_end;    // ptr + 2 == count
    logic       out_free;   // result register can take a new result
  } pal_status_t;

endpackage

// ----- rtl/core/positional_array_list.sv -----
// ----------------------------------------------------------------------------
// positional_array_list
// Ordered list of signed 32-bit words addressed by one-based position, with
// read, modify, insert and delete commands.
// ----------------------------------------------------------------------------
// Each item is one command; it gives one result carrying the old word, the
// count after the command and the empty, full and error flags. Entries live
// in a memory with one registered read port and one write port, and insert
// and delete move the later entries one word per cycle through those ports.
// Read and modify read the entry, and modify then writes the new value. An
// append writes the value during the check; any other insert moves later
// entries up, last one first, then places the value; delete reads the entry
// and moves later entries down; a refused command finishes. The next item is
// taken while the previous result still waits in the output register.
module positional_array_list #(
  parameter int CAPACITY = 128
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         command,
  input  logic [7:0]         position,
  input  logic signed [31:0] value,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] old_value,
  output logic [7:0]         item_count,
  output logic               is_empty,
  output logic               is_full,
  output logic               bad_request
);
  import pal_pkg::*;

  pal_cmd_t    ctl;
  pal_status_t status;

  pal_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .ctl      (ctl)
  );

  pal_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .ctl         (ctl),
    .status      (status),
    .command     (command),
    .position    (position),
    .value       (value),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .old_value   (old_value),
    .item_count  (item_count),
    .is_empty    (is_empty),
    .is_full     (is_full),
    .bad_request (bad_request)
  );

endmodule

// ----- rtl/core/pal_ctrl.sv -----
// ----------------------------------------------------------------------------
// pal_ctrl
// Controller state machine: sequences the checks, reads and shift sweeps of
// one item and hands the result to the output register.
// ----------------------------------------------------------------------------
module pal_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  pal_pkg::pal_status_t status,
  output pal_pkg::pal_cmd_t    ctl
);
  import pal_pkg::*;

  localparam logic [2:0] S_IDLE      = 3'd0;
  localparam logic [2:0] S_CHECK     = 3'd1;
  localparam logic [2:0] S_RD_WAIT   = 3'd2;
  localparam logic [2:0] S_DEL_SHIFT = 3'd3;
  localparam logic [2:0] S_INS_SHIFT = 3'd4;
  localparam logic [2:0] S_INS_PLACE = 3'd5;
  localparam logic [2:0] S_FINISH    = 3'd6;

  logic [2:0] state;
  logic [2:0] state_next;

  // No item is taken while reset is held.
  assign in_stall = rst || (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next    = state;
    ctl           = '0;
    ctl.rd_sel    = RD_AT;
    ctl.wr_sel    = WR_AT_VALUE;
    ctl.ptr_op    = PTR_HOLD;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          ctl.latch  = 1'b1;
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        if (status.bad) begin
          state_next = S_FINISH;
        end else if (status.cmd == CMD_INSERT) begin
          if (status.append) begin
            ctl.wr_en  = 1'b1;
            ctl.wr_sel = WR_AT_VALUE;
            state_next = S_FINISH;
          end else begin
            ctl.rd_en  = 1'b1;
            ctl.rd_sel = RD_LAST;
            ctl.ptr_op = PTR_LOAD_LAST;
            state_next = S_INS_SHIFT;
          end
        end else begin
          ctl.rd_en  = 1'b1;
          ctl.rd_sel = RD_AT;
          ctl.ptr_op = PTR_LOAD_AT;
          state_next = S_RD_WAIT;
        end
      end
      S_RD_WAIT: begin
        ctl.cap_prior = 1'b1;
        state_next    = S_FINISH;
        if (status.cmd == CMD_MODIFY) begin
          ctl.wr_en  = 1'b1;
          ctl.wr_sel = WR_AT_VALUE;
        end else if (status.cmd == CMD_DELETE && !status.del_last) begin
          ctl.rd_en  = 1'b1;
          ctl.rd_sel = RD_PTR_UP1;
          state_next = S_DEL_SHIFT;
        end
      end
      S_DEL_SHIFT: begin
        // Each cycle writes the word read last cycle one place down.
        ctl.wr_en  = 1'b1;
        ctl.wr_sel = WR_PTR;
        ctl.ptr_op = PTR_INC;
        if (status.del_end) begin
          state_next = S_FINISH;
        end else begin
          ctl.rd_en  = 1'b1;
          ctl.rd_sel = RD_PTR_UP2;
        end
      end
      S_INS_SHIFT: begin
        // Each cycle writes the word read last cycle one place up.
        ctl.wr_en  = 1'b1;
        ctl.wr_sel = WR_PTR_UP;
        if (status.ptr_at) begin
          state_next = S_INS_PLACE;
        end else begin
          ctl.rd_en  = 1'b1;
          ctl.rd_sel = RD_PTR_DN;
          ctl.ptr_op = PTR_DEC;
        end
      end
      S_INS_PLACE: begin
        ctl.wr_en  = 1'b1;
        ctl.wr_sel = WR_AT_VALUE;
        state_next = S_FINISH;
      end
      S_FINISH: begin
        if (status.out_free) begin
          ctl.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// ----- rtl/core/pal_dp.sv -----
// ----------------------------------------------------------------------------
// pal_dp
// Datapath: item registers, entry memory, sweep pointer, count and the
// result register.
// ----------------------------------------------------------------------------
module pal_dp #(
  parameter int CAPACITY = 128
) (
  input  logic                 clk,
  input  logic                 rst,
  input  pal_pkg::pal_cmd_t    ctl,
  output pal_pkg::pal_status_t status,
  input  logic [1:0]           command,
  input  logic [7:0]           position,
  input  logic signed [31:0]   value,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic signed [31:0]   old_value,
  output logic [7:0]           item_count,
  output logic                 is_empty,
  output logic                 is_full,
  output logic                 bad_request
);
  import pal_pkg::*;

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int PW = ((CW > 8) ? CW : 8) + 1;

  // Item registers.
  logic [1:0]  cmd;
  logic [7:0]  pos;
  logic [31:0] word;

  logic [CW-1:0] count;
  logic [CW-1:0] count_next;
  logic [AW-1:0] ptr;
  logic [31:0]   prior;
  logic [31:0]   rdata;
  logic [31:0]   mem [CAPACITY];

  logic [PW-1:0] pos_ext;
  logic [PW-1:0] count_ext;
  logic [PW-1:0] ptr_ext;
  logic [AW-1:0] at;
  logic          bad;
  logic [AW-1:0] ra;
  logic [AW-1:0] wa;
  logic [31:0]   wd;

  assign pos_ext   = PW'(pos);
  assign count_ext = PW'(count);
  assign ptr_ext   = PW'(ptr);
  assign at        = AW'(pos_ext - PW'(1));

  always_comb begin
    if (cmd == CMD_INSERT) begin
      bad = (count_ext >= PW'(CAPACITY)) || (pos == 8'd0) ||
            (pos_ext > count_ext + PW'(1));
    end else begin
      bad = (pos == 8'd0) || (pos_ext > count_ext);
    end
  end

  assign status.cmd      = cmd;
  assign status.bad      = bad;
  assign status.append   = (pos_ext == count_ext + PW'(1));
  assign status.ptr_at   = (ptr == at);
  assign status.del_last = (ptr_ext + PW'(1) == count_ext);
  assign status.del_end  = (ptr_ext + PW'(2) == count_ext);
  assign status.out_free = !out_valid || !out_stall;

  always_comb begin
    case (ctl.rd_sel)
      RD_LAST:    ra = AW'(count_ext - PW'(1));
      RD_PTR_DN:  ra = AW'(ptr_ext - PW'(1));
      RD_PTR_UP1: ra = AW'(ptr_ext + PW'(1));
      RD_PTR_UP2: ra = AW'(ptr_ext + PW'(2));
      default:    ra = at;
    endcase
  end

  always_comb begin
    case (ctl.wr_sel)
      WR_PTR_UP: begin
        wa = AW'(ptr_ext + PW'(1));
        wd = rdata;
      end
      WR_PTR: begin
        wa = ptr;
        wd = rdata;
      end
      default: begin
        wa = at;
        wd = word;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[wa] <= wd;
    end
    if (ctl.rd_en) begin
      rdata <= mem[ra];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.latch) begin
      cmd  <= command;
      pos  <= position;
      word <= value;
    end
    if (ctl.cap_prior) begin
      prior <= rdata;
    end
    case (ctl.ptr_op)
      PTR_LOAD_AT:   ptr <= at;
      PTR_LOAD_LAST: ptr <= AW'(count_ext - PW'(1));
      PTR_DEC:       ptr <= AW'(ptr_ext - PW'(1));
      PTR_INC:       ptr <= AW'(ptr_ext + PW'(1));
      default:       ptr <= ptr;
    endcase
  end

  always_comb begin
    count_next = count;
    if (!bad) begin
      if (cmd == CMD_INSERT) begin
        count_next = CW'(count_ext + PW'(1));
      end else if (cmd == CMD_DELETE) begin
        count_next = CW'(count_ext - PW'(1));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (ctl.finish) begin
        count     <= count_next;
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.finish) begin
      old_value   <= (bad || cmd == CMD_INSERT) ? '0 : prior;
      item_count  <= 8'(count_next);
      is_empty    <= (count_next == '0);
      is_full     <= (PW'(count_next) == PW'(CAPACITY));
      bad_request <= bad;
    end
  end

endmodule

// ----- test/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the positional array list. It covers read, modify,
// insert and delete at the ends and the middle of the list, filling the list
// to capacity, and refused commands. A long random phase follows with the
// list length drifting between short and long. Both handshake sides idle at
// random, and every result is checked against an in-bench list model.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb;
  import pal_pkg::*;

  localparam int CAPACITY     = 128;
  localparam int MAX_WAIT     = 12;
  localparam int IDLE_LIMIT   = 3000;
  localparam int RANDOM_ITEMS = 1540;

  typedef struct packed {
    logic signed [31:0] old_value;
    logic [7:0]         item_count;
    logic               is_empty;
    logic               is_full;
    logic               bad_request;
  } list_result_t;

  logic               clk         = 1'b0;
  logic               rst         = 1'b1;
  logic               in_valid    = 1'b0;
  logic               in_stall;
  logic [1:0]         command     = CMD_READ;
  logic [7:0]         position    = 8'd0;
  logic signed [31:0] value       = 32'sd0;
  logic               out_valid;
  logic               out_stall   = 1'b0;
  logic signed [31:0] old_value;
  logic [7:0]         item_count;
  logic               is_empty;
  logic               is_full;
  logic               bad_request;

  // Model of the list contents as the block should hold them.
  logic signed [31:0] list_words [CAPACITY];
  int                 list_len;
  list_result_t       pending_results[$];

  int  errors;
  int  items_sent;
  int  results_seen;
  int  refused_count;
  int  insert_count;
  int  delete_count;
  int  peak_len;
  int  idle_cycles;
  bit  steady;

  positional_array_list #(.CAPACITY(CAPACITY)) dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .command     (command),
    .position    (position),
    .value       (value),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .old_value   (old_value),
    .item_count  (item_count),
    .is_empty    (is_empty),
    .is_full     (is_full),
    .bad_request (bad_request)
  );

  always #10 clk = ~clk;

  function automatic int draw_wait();
    return steady ? 0 : $urandom_range(0, MAX_WAIT);
  endfunction

  function automatic logic signed [31:0] pick_word();
    case ($urandom_range(0, 11))
      0: return 32'sh7fff_ffff;
      1: return 32'sh8000_0000;
      2: return 32'sd0;
      3: return -32'sd1;
      default: return $urandom;
    endcase
  endfunction

  // Applies one command to the list model and returns the result it gives.
  function automatic list_result_t apply_command(logic [1:0] cmd, logic [7:0] pos,
                                                 logic signed [31:0] word);
    list_result_t r;
    int p;
    p = int'(pos);
    r = '0;
    if (cmd == CMD_INSERT) begin
      if (list_len >= CAPACITY || p == 0 || p > list_len + 1) begin
        r.bad_request = 1'b1;
      end else begin
        for (int k = list_len; k > p - 1; k--) list_words[k] = list_words[k - 1];
        list_words[p - 1] = word;
        list_len++;
        insert_count++;
      end
    end else if (p == 0 || p > list_len) begin
      r.bad_request = 1'b1;
    end else begin
      r.old_value = list_words[p - 1];
      if (cmd == CMD_MODIFY) begin
        list_words[p - 1] = word;
      end else if (cmd == CMD_DELETE) begin
        for (int k = p - 1; k + 1 < list_len; k++) list_words[k] = list_words[k + 1];
        list_len--;
        delete_count++;
      end
    end
    if (r.bad_request) refused_count++;
    if (list_len > peak_len) peak_len = list_len;
    r.item_count = 8'(list_len);
    r.is_empty   = (list_len == 0);
    r.is_full    = (list_len == CAPACITY);
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    errors++;
  endtask

  // Called at a rising edge; returns at the edge where the item is taken.
  task automatic send_command(input logic [1:0] cmd, input int pos,
                              input logic signed [31:0] word);
    int gap;
    gap = draw_wait();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    command  <= cmd;
    position <= pos[7:0];
    value    <= word;
    do @(posedge clk); while (in_stall);
    pending_results.push_back(apply_command(cmd, pos[7:0], word));
    items_sent++;
  endtask

  task automatic wait_until_settled();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic test_edge_positions();
    send_command(CMD_READ, 1, 32'sd0);
    send_command(CMD_DELETE, 1, 32'sd0);
    send_command(CMD_MODIFY, 0, 32'sd7);
    send_command(CMD_INSERT, 0, 32'sd5);
    send_command(CMD_INSERT, 2, 32'sd5);
    send_command(CMD_INSERT, 1, 32'sh7fff_ffff);
    send_command(CMD_INSERT, 2, 32'sh8000_0000);
    send_command(CMD_INSERT, 1, 32'sd0);
    send_command(CMD_INSERT, 2, -32'sd1);
    for (int p = 1; p <= 5; p++) send_command(CMD_READ, p, 32'sd0);
    send_command(CMD_READ, 255, 32'sd0);
    send_command(CMD_MODIFY, 4, 32'sh5555_5555);
    send_command(CMD_MODIFY, 1, 32'shaaaa_aaaa);
    send_command(CMD_INSERT, 255, 32'sd1);
    send_command(CMD_DELETE, 4, 32'sd0);
    send_command(CMD_DELETE, 1, 32'sd0);
    send_command(CMD_DELETE, 3, 32'sd0);
    send_command(CMD_DELETE, 1, 32'sd0);
    send_command(CMD_DELETE, 1, 32'sd0);
    send_command(CMD_READ, 1, 32'sd0);
  endtask

  task automatic test_full_list();
    while (list_len < CAPACITY) send_command(CMD_INSERT, list_len + 1, pick_word());
    send_command(CMD_INSERT, 1, 32'sd3);
    send_command(CMD_INSERT, CAPACITY + 1, 32'sd3);
    send_command(CMD_READ, CAPACITY, 32'sd0);
    send_command(CMD_READ, CAPACITY + 1, 32'sd0);
    send_command(CMD_MODIFY, CAPACITY, pick_word());
    send_command(CMD_DELETE, CAPACITY, 32'sd0);
    // Front insert and delete move every entry of a nearly full list.
    send_command(CMD_INSERT, 1, pick_word());
    send_command(CMD_DELETE, 1, 32'sd0);
    wait_until_settled();
  endtask

  task automatic test_random_traffic(input int n);
    int target;
    int roll;
    int pos;
    logic [1:0] cmd;
    target = 8;
    for (int i = 0; i < n; i++) begin
      if (i % 100 == 0) begin
        target = ($urandom_range(0, 4) == 0) ? $urandom_range(60, CAPACITY)
                                             : $urandom_range(0, 24);
        steady = ($urandom_range(0, 3) == 0);
      end
      // Let all outstanding results arrive now and then before going on.
      if (i % 250 == 125) wait_until_settled();
      roll = $urandom_range(0, 99);
      if (roll < 10) begin
        cmd = 2'($urandom_range(0, 3));
        pos = $urandom_range(0, 255);
      end else begin
        if (roll < 30) cmd = CMD_READ;
        else if (roll < 50) cmd = CMD_MODIFY;
        else if ((roll < 75) == (list_len < target)) cmd = CMD_INSERT;
        else cmd = CMD_DELETE;
        if (cmd == CMD_INSERT) pos = $urandom_range(1, list_len + 1);
        else pos = (list_len == 0) ? 1 : $urandom_range(1, list_len);
      end
      send_command(cmd, pos, pick_word());
    end
    steady = 1'b0;
  endtask

  // Result side: random stall after each result, checks against the model.
  always @(posedge clk) begin : result_check
    static int stall_left = 0;
    list_result_t want;
    if (rst) begin
      out_stall <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid && !out_stall) begin
        results_seen++;
        if (pending_results.size() == 0) begin
          report_mismatch($sformatf("result %0d arrived with none outstanding",
                                    results_seen));
        end else begin
          want = pending_results.pop_front();
          if (old_value !== want.old_value)
            report_mismatch($sformatf("result %0d old_value %h, expected %h",
                                      results_seen, old_value, want.old_value));
          if (item_count !== want.item_count)
            report_mismatch($sformatf("result %0d item_count %0d, expected %0d",
                                      results_seen, item_count, want.item_count));
          if (is_empty !== want.is_empty)
            report_mismatch($sformatf("result %0d is_empty %b, expected %b",
                                      results_seen, is_empty, want.is_empty));
          if (is_full !== want.is_full)
            report_mismatch($sformatf("result %0d is_full %b, expected %b",
                                      results_seen, is_full, want.is_full));
          if (bad_request !== want.bad_request)
            report_mismatch($sformatf("result %0d bad_request %b, expected %b",
                                      results_seen, bad_request, want.bad_request));
        end
        stall_left = draw_wait();
      end
      if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Ends the run if neither side moves an item for too long.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("timeout: no handshake for %0d cycles", IDLE_LIMIT);
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  initial begin
    list_len = 0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    test_edge_positions();
    test_full_list();
    test_random_traffic(RANDOM_ITEMS);
    wait_until_settled();
    repeat (200) @(posedge clk);
    if (pending_results.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", pending_results.size()));
    $display("sent %0d commands, checked %0d results: %0d refused, %0d inserts,",
             items_sent, results_seen, refused_count, insert_count);
    $display("%0d deletes, list length peaked at %0d of %0d", delete_count,
             peak_len, CAPACITY);
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ----- positional_array_list.f -----
rtl/core/pal_pkg.sv
rtl/core/pal_ctrl.sv
rtl/core/pal_dp.sv
rtl/core/positional_array_list.sv
test/tb.sv
